[src/rau_pkg.sv]
// Package for the rational arithmetic unit: widths, operation codes and
// shared types. No dependencies.
package rau_pkg;

  localparam int OperandWidth = 16;
  localparam int MagWidth     = 2 * OperandWidth + 1;
  localparam int NumWidth     = 33;
  localparam int DenWidth     = 31;
  localparam int OpWidth      = 3;
  localparam int CntWidth     = $clog2(MagWidth + 1);

  typedef enum logic [OpWidth-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_RECIP = 3'd4
  } op_t;

  typedef logic [MagWidth-1:0] mag_t;

  // request to the shared divider
  typedef struct packed {
    logic start;
    mag_t dividend;
    mag_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    mag_t quotient;
    mag_t remainder;
  } div_rsp_t;

endpackage

[src/rational_arithmetic_unit.sv]
// Rational arithmetic unit: sequencer around one shared iterative divider.
// Flow: a zero input denominator goes from S_PREP straight to S_OUT with an error.
// Otherwise each divide is a start, the 33 quotient bits and a done, and an
// item runs the Euclid steps plus two exact divides per gcd, one gcd for
// mul/div/recip and two for add/sub.
// Throughput: one item at a time; in_ready is high only when idle. A finished
// result waits in S_OUT while the output register still holds an unaccepted beat.
// Reset: synchronous active-low rst_n returns the sequencer to idle, no output.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OpWidth-1:0]            in_operation,
  input  logic signed [OperandWidth-1:0] in_first_numerator,
  input  logic signed [OperandWidth-1:0] in_first_denominator,
  input  logic signed [OperandWidth-1:0] in_second_numerator,
  input  logic signed [OperandWidth-1:0] in_second_denominator,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [NumWidth-1:0]    out_result_numerator,
  output logic [DenWidth-1:0]           out_result_denominator,
  output logic                          out_error_code
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_PREP  = 8'b00000010,
    S_G1    = 8'b00000100,
    S_L1    = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_G2    = 8'b00100000,
    S_RED   = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  localparam int SW = MagWidth + 1;     // signed working width
  localparam int PW = OperandWidth + 1; // operand width after sign normalization

  state_t               st_r, st_nxt;
  logic [OpWidth-1:0]   op_r, op_nxt;
  logic signed [SW-1:0] n1_r, n1_nxt, d1_r, d1_nxt, n2_r, n2_nxt, d2_r, d2_nxt;
  logic signed [SW-1:0] rn_r, rn_nxt;
  mag_t                 rd_r, rd_nxt;
  logic                 er_r, er_nxt;
  mag_t                 ga_r, ga_nxt, gb_r, gb_nxt;
  logic                 sub_r, sub_nxt; // divide step in flight
  logic                 red_r, red_nxt; // 0: first value (d1 or numerator), 1: second (d2 or denominator)
  logic signed [NumWidth-1:0] on_r, on_nxt;
  logic [DenWidth-1:0]  od_r, od_nxt;
  logic                 oe_r, oe_nxt;
  logic                 ov_r, ov_nxt;
  div_req_t             dreq;
  div_rsp_t             drsp;
  logic signed [PW-1:0] mn1, mn2, md1, ma, mb;
  logic signed [SW-1:0] pm1, pm2, pm3;
  mag_t                 rn_mag;
  logic                 is_sum;

  rau_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign is_sum = (op_r == OP_ADD) || (op_r == OP_SUB);
  assign rn_mag = rn_r[SW-1] ? MagWidth'(-rn_r) : MagWidth'(rn_r);
  assign mn1    = PW'(n1_r);
  assign mn2    = PW'(n2_r);
  assign md1    = PW'(d1_r);
  // sum: gb_r holds d2/g and d1_r holds d1/g
  assign ma     = is_sum ? PW'(gb_r) : (op_r == OP_DIV) ? PW'(d2_r) : mn2;
  assign mb     = (op_r == OP_DIV) ? mn2 : PW'(d2_r);
  assign pm1    = mn1 * ma;
  assign pm2    = md1 * mb;
  assign pm3    = mn2 * md1;

  always_comb begin
    st_nxt  = st_r;
    op_nxt  = op_r;
    n1_nxt  = n1_r; d1_nxt = d1_r; n2_nxt = n2_r; d2_nxt = d2_r;
    rn_nxt  = rn_r; rd_nxt = rd_r; er_nxt = er_r;
    ga_nxt  = ga_r; gb_nxt = gb_r;
    sub_nxt = sub_r; red_nxt = red_r;
    on_nxt  = on_r; od_nxt = od_r; oe_nxt = oe_r;
    ov_nxt  = ov_r;
    dreq    = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_operation;
          n1_nxt = SW'(in_first_numerator);
          d1_nxt = SW'(in_first_denominator);
          n2_nxt = SW'(in_second_numerator);
          d2_nxt = SW'(in_second_denominator);
          st_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (d1_r == 0 || (op_r <= OP_DIV && d2_r == 0)) begin
          er_nxt = 1'b1; rn_nxt = '0; rd_nxt = '0;
          st_nxt = S_OUT;
        end else begin
          if (d1_r < 0) begin
            n1_nxt = -n1_r; d1_nxt = -d1_r;
          end
          if (op_r <= OP_DIV && d2_r < 0) begin
            n2_nxt = -n2_r; d2_nxt = -d2_r;
          end
          if (op_r <= OP_SUB) begin
            ga_nxt = MagWidth'(d1_r < 0 ? -d1_r : d1_r);
            gb_nxt = MagWidth'(d2_r < 0 ? -d2_r : d2_r);
            sub_nxt = 1'b0;
            st_nxt = S_G1;
          end else begin
            st_nxt = S_MUL;
          end
        end
      end
      S_G1: begin
        // Euclid on d1,d2
        if (!sub_r) begin
          if (gb_r == '0) begin
            red_nxt = 1'b0;
            st_nxt = S_L1;
          end else begin
            dreq.start = 1'b1; dreq.dividend = ga_r; dreq.divisor = gb_r;
            sub_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          ga_nxt = gb_r; gb_nxt = drsp.remainder; sub_nxt = 1'b0;
        end
      end
      S_L1: begin
        // exact divides by g: d1/g into d1_r, then d2/g into gb_r
        if (!sub_r) begin
          dreq.start = 1'b1;
          dreq.dividend = MagWidth'(red_r ? d2_r : d1_r);
          dreq.divisor = ga_r;
          sub_nxt = 1'b1;
        end else if (drsp.done) begin
          sub_nxt = 1'b0;
          if (!red_r) begin
            d1_nxt = SW'(drsp.quotient);
            red_nxt = 1'b1;
          end else begin
            gb_nxt = drsp.quotient;
            st_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        if (is_sum) begin
          // l = (d1/g)*d2, a = n1*(d2/g), b = n2*(d1/g)
          rn_nxt = (op_r == OP_ADD) ? pm1 + pm3 : pm1 - pm3;
          rd_nxt = MagWidth'(pm2);
        end else if (op_r == OP_MUL || op_r == OP_DIV) begin
          if (pm2 < 0) begin
            rn_nxt = -pm1;
            rd_nxt = MagWidth'(-pm2);
          end else begin
            rn_nxt = pm1;
            rd_nxt = MagWidth'(pm2);
          end
        end else begin
          rn_nxt = n1_r[SW-1] ? -d1_r : d1_r;
          rd_nxt = MagWidth'(n1_r[SW-1] ? -n1_r : n1_r);
        end
        st_nxt = S_G2;
        ga_nxt = '0; gb_nxt = '0;
        sub_nxt = 1'b0;
        red_nxt = 1'b0;
      end
      S_G2: begin
        if (rd_r == '0) begin
          er_nxt = 1'b1; rn_nxt = '0; rd_nxt = '0; st_nxt = S_OUT;
        end else if (rn_r == 0) begin
          er_nxt = 1'b0; rd_nxt = MagWidth'(1); st_nxt = S_OUT;
        end else if (!sub_r && ga_r == '0 && gb_r == '0) begin
          ga_nxt = rn_mag; gb_nxt = rd_r;
        end else if (!sub_r) begin
          if (gb_r == '0) begin
            st_nxt = S_RED;
          end else begin
            dreq.start = 1'b1; dreq.dividend = ga_r; dreq.divisor = gb_r;
            sub_nxt = 1'b1;
          end
        end else if (drsp.done) begin
          ga_nxt = gb_r; gb_nxt = drsp.remainder; sub_nxt = 1'b0;
        end
      end
      S_RED: begin
        if (!sub_r) begin
          dreq.start = 1'b1;
          dreq.dividend = red_r ? rd_r : rn_mag;
          dreq.divisor = ga_r;
          sub_nxt = 1'b1;
        end else if (drsp.done) begin
          sub_nxt = 1'b0;
          if (!red_r) begin
            rn_nxt = rn_r[SW-1] ? -SW'(drsp.quotient) : SW'(drsp.quotient);
            red_nxt = 1'b1;
          end else begin
            er_nxt = 1'b0;
            rd_nxt = drsp.quotient;
            st_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        // load the output register once the previous beat is gone
        if (!ov_r || out_ready) begin
          on_nxt = NumWidth'(rn_r);
          od_nxt = DenWidth'(rd_r);
          oe_nxt = er_r;
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    n1_r <= n1_nxt; d1_r <= d1_nxt; n2_r <= n2_nxt; d2_r <= d2_nxt;
    rn_r <= rn_nxt; rd_r <= rd_nxt; er_r <= er_nxt;
    ga_r <= ga_nxt; gb_r <= gb_nxt;
    red_r <= red_nxt;
    on_r <= on_nxt; od_r <= od_nxt; oe_r <= oe_nxt;
    if (!rst_n) begin
      st_r  <= S_IDLE;
      sub_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sub_r <= sub_nxt;
      ov_r  <= ov_nxt;
    end
  end

  assign in_ready               = (st_r == S_IDLE);
  assign out_valid              = ov_r;
  assign out_result_numerator   = on_r;
  assign out_result_denominator = od_r;
  assign out_error_code         = oe_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code |-> out_result_denominator == '0)
    else $error("error beat with nonzero denominator");
  a_ok_den: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_error_code |-> out_result_denominator != '0)
    else $error("ok beat with zero denominator");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

[src/rau_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on rau_pkg.
module rau_divider
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  mag_t                quo_r, quo_nxt;
  mag_t                rem_r, rem_nxt;
  mag_t                dvs_r, dvs_nxt;
  logic [CntWidth-1:0] cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [MagWidth:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[MagWidth-1]};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CntWidth'(MagWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = MagWidth'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[MagWidth-2:0], 1'b1};
      end else begin
        rem_nxt = trial[MagWidth-1:0];
        quo_nxt = {quo_r[MagWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntWidth'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

[test/rational_arithmetic_unit_tb.sv]
// Testbench for rational_arithmetic_unit: random and directed fractions, a
// scoreboard predicting each reduced result. Depends on rau_pkg and the block.
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam int RandomItems = 650;
  localparam int CycleLimit  = 10000000;
  localparam int HoldCycles  = 3000;

  typedef struct {
    logic [NumWidth-1:0] num;
    logic [DenWidth-1:0] den;
    logic                err;
  } fraction_t;

  class fraction_scoreboard;
    fraction_t pending[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    static function longint unsigned gcd64(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    // compute the reduced fraction for one accepted beat
    function void note_input(logic [OpWidth-1:0] op, logic signed [OperandWidth-1:0] an,
                             logic signed [OperandWidth-1:0] ad,
                             logic signed [OperandWidth-1:0] bn,
                             logic signed [OperandWidth-1:0] bd);
      longint n1, d1, n2, d2, rn, rd, l;
      longint unsigned g, m;
      bit two_operand;
      fraction_t f;
      n1 = an; d1 = ad; n2 = bn; d2 = bd;
      rn = 0; rd = 0;
      f.err = 0;
      two_operand = (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_DIV);
      if (d1 == 0 || (two_operand && d2 == 0)) begin
        f.err = 1;
      end else begin
        if (d1 < 0) begin n1 = -n1; d1 = -d1; end
        if (two_operand && d2 < 0) begin n2 = -n2; d2 = -d2; end
        case (op)
          OP_ADD, OP_SUB: begin
            g = gcd64(d1, d2);
            l = (d1 / longint'(g)) * d2;
            rn = (op == OP_ADD) ? n1 * (l / d1) + n2 * (l / d2)
                                : n1 * (l / d1) - n2 * (l / d2);
            rd = l;
          end
          OP_MUL: begin rn = n1 * n2; rd = d1 * d2; end
          OP_DIV: begin rn = n1 * d2; rd = d1 * n2; end
          default: begin rn = d1; rd = n1; end
        endcase
        if (rd == 0) begin
          f.err = 1;
        end else begin
          if (rd < 0) begin rn = -rn; rd = -rd; end
          if (rn == 0) begin
            rd = 1;
          end else begin
            m = (rn < 0) ? -rn : rn;
            g = gcd64(m, rd);
            rn = rn / longint'(g);
            rd = rd / longint'(g);
          end
        end
      end
      if (f.err) begin
        f.num = '0;
        f.den = '0;
      end else begin
        f.num = rn[NumWidth-1:0];
        f.den = rd[DenWidth-1:0];
      end
      pending.push_back(f);
    endfunction

    task check(logic [NumWidth-1:0] num, logic [DenWidth-1:0] den, logic err);
      fraction_t f;
      if (pending.size() == 0) begin
        report("result beat with nothing pending", 0, 0);
      end else begin
        f = pending.pop_front();
        if (num !== f.num) report("numerator", longint'(signed'(num)),
                                  longint'(signed'(f.num)));
        if (den !== f.den) report("denominator", den, f.den);
        if (err !== f.err) report("error_code", err, f.err);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [OpWidth-1:0] in_operation = '0;
  logic signed [OperandWidth-1:0] in_first_numerator = '0;
  logic signed [OperandWidth-1:0] in_first_denominator = '0;
  logic signed [OperandWidth-1:0] in_second_numerator = '0;
  logic signed [OperandWidth-1:0] in_second_denominator = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [NumWidth-1:0] out_result_numerator;
  logic [DenWidth-1:0] out_result_denominator;
  logic out_error_code;

  fraction_scoreboard sb = new();
  int  cycles = 0;
  bit  hold_request = 0;

  rational_arithmetic_unit DUT (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("rational_arithmetic_unit_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check(out_result_numerator, out_result_denominator, out_error_code);
  end

  // receiver: a randomly chosen stall pattern, changed when its random run ends, plus one long hold
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready = 0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_request = 0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(10, 200);
      end
      left--;
      case (mode)
        0: out_ready = 1;
        1: out_ready = $urandom_range(0, 1);
        2: out_ready = ($urandom_range(0, 7) == 0);
        default: out_ready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task send(logic [OpWidth-1:0] op, logic signed [OperandWidth-1:0] an,
            logic signed [OperandWidth-1:0] ad, logic signed [OperandWidth-1:0] bn,
            logic signed [OperandWidth-1:0] bd);
    @(negedge clk);
    in_valid = 1;
    in_operation = op;
    in_first_numerator = an;
    in_first_denominator = ad;
    in_second_numerator = bn;
    in_second_denominator = bd;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, an, ad, bn, bd);
  endtask

  task idle(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 0;
    end
  endtask

  function automatic logic signed [OperandWidth-1:0] pick_value(int kind);
    case (kind)
      0: return OperandWidth'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return OperandWidth'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic logic signed [OperandWidth-1:0] pick_den(int kind);
    logic signed [OperandWidth-1:0] v;
    if ($urandom_range(0, 19) == 0) return '0;
    v = pick_value(kind);
    return (v == 0) ? 16'sd1 : v;
  endfunction

  initial begin
    int burst, kind;
    logic [OpWidth-1:0] op;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    send(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
    send(OP_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
    send(OP_MUL, -16'sd3, 16'sd4, 16'sd4, -16'sd3);
    send(OP_DIV, 16'sd2, 16'sd3, 16'sd4, 16'sd9);
    send(OP_RECIP, -16'sd6, 16'sd4, 16'sd0, 16'sd0);
    send(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe);
    send(OP_SUB, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000);
    send(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send(OP_MUL, 16'sh8000, 16'sd1, 16'sh8000, 16'sd1);
    send(OP_DIV, 16'sh8000, 16'sd1, 16'sd1, 16'sh8000);
    send(OP_DIV, 16'sh7fff, 16'sh8001, 16'sh8000, 16'sh7fff);
    send(OP_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd1);
    send(OP_SUB, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
    send(OP_DIV, 16'sd1, 16'sd2, 16'sd0, 16'sd5);
    send(OP_RECIP, 16'sd0, 16'sd5, 16'sd1, 16'sd1);
    send(OP_RECIP, 16'sd3, 16'sd0, 16'sd0, 16'sd0);
    send(OP_RECIP, 16'sd7, -16'sd21, 16'sd5, 16'sd0);
    send(OP_MUL, 16'sd0, -16'sd7, 16'sd5, 16'sd3);
    send(OP_ADD, -16'sd1, 16'sd3, 16'sd1, 16'sd3);
    send(3'd5, 16'sd4, 16'sd6, 16'sd1, 16'sd1);
    send(3'd6, -16'sd5, 16'sd10, 16'sd0, 16'sd0);
    send(3'd7, 16'sh8000, 16'sh7fff, 16'shffff, 16'shffff);
    idle(3);

    for (int i = 0; i < RandomItems; ) begin
      burst = $urandom_range(1, 16);
      for (int j = 0; j < burst && i < RandomItems; j++, i++) begin
        if (i == 200) hold_request = 1;
        if (i == 400) begin
          idle(1);
          while (sb.pending.size() != 0) @(negedge clk);
        end
        op = OpWidth'(($urandom_range(0, 15) == 0) ? $urandom_range(5, 7)
                                                   : $urandom_range(0, 4));
        kind = $urandom_range(0, 9);
        kind = (kind < 3) ? 0 : (kind == 3) ? 1 : 2;
        send(op, pick_value(kind), pick_den(kind), pick_value(kind), pick_den(kind));
      end
      idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40));
    end
    idle(1);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("rational_arithmetic_unit_tb: PASS");
    end else begin
      $display("rational_arithmetic_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
